// File: rtl/gau_pkg.sv
`default_nettype none
package gau_pkg;

  localparam int DATA_W        = 16;
  localparam int FRAC_BITS     = 12;
  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W         = 8;
  localparam int SIG_W         = 17;
  localparam int XI_W          = 20;
  localparam int X2_W          = 24;
  localparam int X3_W          = 27;
  localparam int CX_W          = 20;
  localparam int W_W           = 21;
  localparam int IN_W          = 22;
  localparam int T1_W          = 23;
  localparam int Z_W           = 23;
  localparam int P16_W         = 16;
  localparam int D_W           = 24;
  localparam int ACT_W         = 17;
  localparam int CFG_DATA_W    = 2;

  localparam logic signed [25:0] C_Q24  = 26'sd13386282;
  localparam logic signed [25:0] K_Q24  = 26'sd750193;
  localparam logic signed [25:0] K3_Q24 = 26'sd2250579;
  localparam logic signed [63:0] ONE_Q16 = 64'sd65536;
  localparam logic signed [63:0] SIG_SPAN = 64'sd524288;

  typedef enum logic [1:0] {
    ACT_SWIGLU   = 2'd0,
    ACT_GEGLU    = 2'd1,
    ACT_REGLU    = 2'd2,
    ACT_IDENTITY = 2'd3
  } act_kind_e;

  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_ACT_KIND = 1'b0;
  localparam cfg_idx_t CFG_BACKWARD = 1'b1;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] g;
    logic signed [DATA_W-1:0] go;
    logic                     last;
  } elem_t;

  typedef struct packed {
    elem_t                  e;
    logic signed [XI_W-1:0] xi;
    logic signed [T1_W-1:0] t1;
    logic signed [Z_W-1:0]  z;
  } front_t;

  typedef struct packed {
    front_t           f;
    logic [SIG_W-1:0] s;
  } sig_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] primary;
    logic signed [DATA_W-1:0] secondary;
    logic                     saturated;
    logic                     last;
  } res_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     clip;
  } sat_t;

  typedef logic [SIG_W-1:0] rom_t [TABLE_ENTRIES];

  // Shift right by n with rounding to nearest, ties away from zero.
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                 input int unsigned n);
    logic signed [63:0] h;
    h = 64'sd1 <<< (n - 1);
    return (v + h - $signed({63'd0, v[63]})) >>> n;
  endfunction

  // Clip a rounded value to the signed result range.
  function automatic sat_t sat_q(input logic signed [63:0] v);
    sat_t r;
    if (v > 64'sd32767) begin
      r.val  = 16'sh7FFF;
      r.clip = 1'b1;
    end else if (v < -64'sd32768) begin
      r.val  = 16'sh8000;
      r.clip = 1'b1;
    end else begin
      r.val  = DATA_W'(v);
      r.clip = 1'b0;
    end
    return r;
  endfunction

  // Unsigned long division by shift and subtract, used only to build constants.
  function automatic longint unsigned long_div(input longint unsigned num,
                                               input longint unsigned dvs);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= dvs) begin
        rem    = rem - dvs;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Sigmoid samples over [-8,8) in Q16, built in integer arithmetic.
  function automatic rom_t build_sig_rom();
    rom_t                rom;
    longint unsigned     n;
    longint unsigned     two_k;
    longint unsigned     span;
    longint unsigned     b;
    longint unsigned     sum;
    longint unsigned     term;
    longint unsigned     e;
    longint unsigned     den;
    n = 64'(TABLE_ENTRIES);
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      two_k = 64'(2 * k);
      span  = (two_k >= n) ? two_k - n : n - two_k;
      b     = ((span << 30) + (n >> 1)) >> IDX_W;
      sum   = 64'd1 << 30;
      term  = 64'd1 << 30;
      for (int i = 1; i <= 20; i++) begin
        term = long_div((term * b) >> 30, 64'(i));
        sum  = sum + term;
      end
      e = (sum + 64'd32) >> 6;
      for (int i = 0; i < 3; i++) begin
        e = (e * e + (64'd1 << 23)) >> 24;
      end
      den = (64'd1 << 24) + e;
      if (two_k >= n) begin
        rom[k] = SIG_W'(long_div(64'd65536 * e + (den >> 1), den));
      end else begin
        rom[k] = SIG_W'(long_div((64'd65536 << 24) + (den >> 1), den));
      end
    end
    return rom;
  endfunction

  localparam rom_t SIG_ROM = build_sig_rom();

endpackage
`default_nettype wire

// File: rtl/gau_in_if.sv
`default_nettype none
interface gau_in_if;
  import gau_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] x_value;
  logic signed [DATA_W-1:0] gate_value;
  logic signed [DATA_W-1:0] upstream_grad;
  logic                     last_in;
  modport source(output valid, x_value, gate_value, upstream_grad, last_in, input ready);
  modport sink(input valid, x_value, gate_value, upstream_grad, last_in, output ready);
endinterface
`default_nettype wire

// File: rtl/gau_out_if.sv
`default_nettype none
interface gau_out_if;
  import gau_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] primary_out;
  logic signed [DATA_W-1:0] secondary_out;
  logic                     saturated;
  logic                     last_out;
  modport source(output valid, primary_out, secondary_out, saturated, last_out, input ready);
  modport sink(input valid, primary_out, secondary_out, saturated, last_out, output ready);
endinterface
`default_nettype wire

// File: rtl/gau_front.sv
`default_nettype none
module gau_front (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  gau_pkg::act_kind_e       kind_i,
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  input  gau_pkg::elem_t           in_data_i,
  output logic                     out_valid_o,
  input  wire                      out_ready_i,
  output gau_pkg::front_t          out_data_o
);
  import gau_pkg::*;

  localparam int NS = 4;

  logic [NS-1:0] vld_q;
  logic [NS-1:0] adv;

  elem_t                  e1_q, e2_q, e3_q;
  logic signed [XI_W-1:0] xi1_q, xi2_q, xi3_q;
  logic signed [X2_W-1:0] x2_q;
  logic signed [CX_W-1:0] cx1_q, cx2_q;
  logic signed [X3_W-1:0] x3_q;
  logic signed [W_W-1:0]  w_q;
  logic signed [IN_W-1:0] inner_q;
  logic signed [T1_W-1:0] t1_q, t1o_q;
  logic signed [Z_W-1:0]  z_q;
  elem_t                  e4_q;
  logic signed [XI_W-1:0] xi4_q;

  logic signed [XI_W-1:0] xi_in;
  logic signed [39:0]     sq_p;
  logic signed [45:0]     cx_p;
  logic signed [43:0]     x3_p;
  logic signed [45:0]     w_p;
  logic signed [53:0]     in_p;
  logic signed [40:0]     t1_p;
  logic signed [47:0]     u_p;
  logic signed [X2_W-1:0] x2_d;
  logic signed [CX_W-1:0] cx_d;
  logic signed [X3_W-1:0] x3_d;
  logic signed [W_W-1:0]  w_d;
  logic signed [IN_W-1:0] inner_d;
  logic signed [T1_W-1:0] t1_d;
  logic signed [Z_W-1:0]  z_d;

  always_comb begin
    adv[NS-1] = !vld_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[NS-1];

  // Stage 1: x squared and c*x.
  assign xi_in = $signed({in_data_i.x, 4'b0000});
  assign sq_p  = 40'(xi_in) * 40'(xi_in);
  assign cx_p  = 46'(xi_in) * 46'(C_Q24);
  assign x2_d  = X2_W'(rnd_shr(64'(sq_p), 16));
  assign cx_d  = CX_W'(rnd_shr(64'(cx_p), 24));

  // Stage 2: x cubed and the slope term 1 + 3k*x^2.
  assign x3_p = 44'(x2_q) * 44'(xi1_q);
  assign w_p  = 46'(x2_q) * 46'(K3_Q24);
  assign x3_d = X3_W'(rnd_shr(64'(x3_p), 16));
  assign w_d  = W_W'(ONE_Q16 + rnd_shr(64'(w_p), 24));

  // Stage 3: inner polynomial and c*x*(1 + 3k*x^2).
  assign in_p    = 54'(x3_q) * 54'(K_Q24);
  assign t1_p    = 41'(cx2_q) * 41'(w_q);
  assign inner_d = IN_W'(64'(xi2_q) + rnd_shr(64'(in_p), 24));
  assign t1_d    = T1_W'(rnd_shr(64'(t1_p), 16));

  // Stage 4: sigmoid argument, 2u for the tanh form, x otherwise.
  assign u_p = 48'(inner_q) * 48'(C_Q24);
  always_comb begin
    if (kind_i == ACT_GEGLU) begin
      z_d = Z_W'(rnd_shr(64'(u_p), 24) <<< 1);
    end else begin
      z_d = Z_W'(xi3_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      e1_q  <= in_data_i;
      xi1_q <= xi_in;
      x2_q  <= x2_d;
      cx1_q <= cx_d;
    end
    if (adv[1]) begin
      e2_q  <= e1_q;
      xi2_q <= xi1_q;
      cx2_q <= cx1_q;
      x3_q  <= x3_d;
      w_q   <= w_d;
    end
    if (adv[2]) begin
      e3_q    <= e2_q;
      xi3_q   <= xi2_q;
      inner_q <= inner_d;
      t1_q    <= t1_d;
    end
    if (adv[3]) begin
      e4_q  <= e3_q;
      xi4_q <= xi3_q;
      t1o_q <= t1_q;
      z_q   <= z_d;
    end
  end

  assign out_data_o.e  = e4_q;
  assign out_data_o.xi = xi4_q;
  assign out_data_o.t1 = t1o_q;
  assign out_data_o.z  = z_q;

  a_square_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> !x2_q[X2_W-1])
    else $error("x squared came out negative");

endmodule
`default_nettype wire

// File: rtl/gau_sigmoid.sv
`default_nettype none
module gau_sigmoid (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  input  gau_pkg::front_t          in_data_i,
  output logic                     out_valid_o,
  input  wire                      out_ready_i,
  output gau_pkg::sig_t            out_data_o
);
  import gau_pkg::*;

  localparam int NS = 3;

  logic [NS-1:0] vld_q;
  logic [NS-1:0] adv;

  front_t              f1_q, f2_q, f3_q;
  logic [IDX_W-1:0]    idx_q;
  logic [11:0]         r1_q, r2_q;
  logic                top_q, top2_q;
  logic [SIG_W-1:0]    e0_q;
  logic signed [SIG_W:0] diff_q;
  logic [SIG_W-1:0]    s_q;

  logic signed [63:0]  zc;
  logic [20:0]         off;
  logic [IDX_W-1:0]    idx_d;
  logic                top_d;
  logic [IDX_W-1:0]    rd_idx;
  logic [SIG_W-1:0]    e0_d;
  logic [SIG_W-1:0]    e1_d;
  logic signed [SIG_W:0] diff_d;
  logic signed [30:0]  ip;
  logic [SIG_W-1:0]    s_d;

  always_comb begin
    adv[NS-1] = !vld_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[NS-1];

  // Stage 1: clamp to [-8,8] and split into table index and fraction.
  always_comb begin
    if (64'(in_data_i.z) < -SIG_SPAN) begin
      zc = -SIG_SPAN;
    end else if (64'(in_data_i.z) > SIG_SPAN) begin
      zc = SIG_SPAN;
    end else begin
      zc = 64'(in_data_i.z);
    end
  end
  assign off   = 21'(zc + SIG_SPAN);
  assign idx_d = off[19:12];
  assign top_d = off[20] || (off[19:12] == IDX_W'(TABLE_ENTRIES - 1));

  // Stage 2: read the neighbouring samples.
  assign rd_idx = top_q ? IDX_W'(TABLE_ENTRIES - 1) : idx_q;
  assign e0_d   = SIG_ROM[rd_idx];
  assign e1_d   = SIG_ROM[idx_q + 8'd1];
  assign diff_d = top_q ? '0 : ($signed({1'b0, e1_d}) - $signed({1'b0, e0_d}));

  // Stage 3: linear interpolation.
  assign ip  = 31'(diff_q) * 31'($signed({1'b0, r2_q}));
  assign s_d = SIG_W'(64'($signed({1'b0, e0_q})) + rnd_shr(64'(ip), 12));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      f1_q  <= in_data_i;
      idx_q <= idx_d;
      r1_q  <= off[11:0];
      top_q <= top_d;
    end
    if (adv[1]) begin
      f2_q   <= f1_q;
      r2_q   <= r1_q;
      top2_q <= top_q;
      e0_q   <= e0_d;
      diff_q <= diff_d;
    end
    if (adv[2]) begin
      f3_q <= f2_q;
      s_q  <= s_d;
    end
  end

  assign out_data_o.f = f3_q;
  assign out_data_o.s = s_q;

  a_sig_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> s_q <= SIG_W'(65536))
    else $error("sigmoid above one");

  a_top_flat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] && top2_q |-> diff_q == '0)
    else $error("slope not zero at the top of the table");

endmodule
`default_nettype wire

// File: rtl/gau_back.sv
`default_nettype none
module gau_back (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  gau_pkg::act_kind_e       kind_i,
  input  wire                      backward_i,
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  input  gau_pkg::sig_t            in_data_i,
  output logic                     out_valid_o,
  input  wire                      out_ready_i,
  output gau_pkg::res_t            out_data_o
);
  import gau_pkg::*;

  localparam int NS = 6;

  logic [NS-1:0] vld_q;
  logic [NS-1:0] adv;

  sig_t                    st1_q;
  logic signed [P16_W-1:0] p16_q;
  logic signed [ACT_W-1:0] acts_q;
  elem_t                   e2_q, e3_q, e4_q;
  logic signed [D_W-1:0]   d_q;
  logic signed [ACT_W-1:0] act_q;
  logic signed [39:0]      pm_q;
  logic signed [32:0]      pa_q, pa4_q, pa5_q;
  logic signed [32:0]      pr2_q, pr24_q, pr25_q;
  logic signed [D_W-1:0]   m_q;
  logic signed [39:0]      pb_q;
  logic                    last5_q;
  res_t                    res_q;

  logic signed [SIG_W:0]   s_in;
  logic signed [SIG_W:0]   one_m;
  logic signed [35:0]      pp;
  logic signed [33:0]      ap;
  logic signed [P16_W-1:0] p16_d;
  logic signed [ACT_W-1:0] acts_d;
  logic signed [35:0]      sw_p;
  logic signed [39:0]      ge_p;
  logic signed [D_W-1:0]   d_d;
  logic signed [ACT_W-1:0] act_d;
  logic signed [D_W-1:0]   m_d;
  sat_t                    r1, r2;
  res_t                    res_d;

  always_comb begin
    adv[NS-1] = !vld_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[NS-1];

  // Stage 1: s*(1-s) and x*s.
  assign s_in   = $signed({1'b0, in_data_i.s});
  assign one_m  = (SIG_W + 1)'(ONE_Q16) - s_in;
  assign pp     = 36'(s_in) * 36'(one_m);
  assign ap     = 34'(in_data_i.f.e.x) * 34'(s_in);
  assign p16_d  = P16_W'(rnd_shr(64'(pp), 16));
  assign acts_d = ACT_W'(rnd_shr(64'(ap), 16));

  // Stage 2: derivative and activation for the selected mode. The tanh slope
  // is doubled after widening, as 2*t1 needs one bit more than t1.
  assign sw_p = 36'(st1_q.f.xi) * 36'(p16_q);
  assign ge_p = (40'(st1_q.f.t1) <<< 1) * 40'(p16_q);
  always_comb begin
    case (kind_i)
      ACT_SWIGLU: begin
        d_d   = D_W'(64'($signed({1'b0, st1_q.s})) + rnd_shr(64'(sw_p), 16));
        act_d = acts_q;
      end
      ACT_GEGLU: begin
        d_d   = D_W'(64'($signed({1'b0, st1_q.s})) + rnd_shr(64'(ge_p), 16));
        act_d = acts_q;
      end
      ACT_REGLU: begin
        d_d   = (st1_q.f.e.x > 0) ? D_W'(ONE_Q16) : '0;
        act_d = (st1_q.f.e.x > 0) ? ACT_W'(st1_q.f.e.x) : '0;
      end
      default: begin
        d_d   = D_W'(ONE_Q16);
        act_d = ACT_W'(st1_q.f.e.x);
      end
    endcase
  end

  // Stage 4: gradient through the activation, back to Q16 scale.
  assign m_d = D_W'(rnd_shr(64'(pm_q), 16));

  // Stage 6: final rounding and clipping.
  always_comb begin
    r1 = sat_q(rnd_shr(64'(backward_i ? pb_q : 40'(pa5_q)), FRAC_BITS));
    r2 = sat_q(rnd_shr(64'(pr25_q), FRAC_BITS));
    res_d.primary   = r1.val;
    res_d.secondary = backward_i ? r2.val : '0;
    res_d.saturated = r1.clip || (backward_i && r2.clip);
    res_d.last      = last5_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      st1_q  <= in_data_i;
      p16_q  <= p16_d;
      acts_q <= acts_d;
    end
    if (adv[1]) begin
      e2_q  <= st1_q.f.e;
      d_q   <= d_d;
      act_q <= act_d;
    end
    if (adv[2]) begin
      e3_q  <= e2_q;
      pm_q  <= 40'(e2_q.go) * 40'(d_q);
      pa_q  <= 33'(act_q) * 33'(e2_q.g);
      pr2_q <= 33'(e2_q.go) * 33'(act_q);
    end
    if (adv[3]) begin
      e4_q   <= e3_q;
      m_q    <= m_d;
      pa4_q  <= pa_q;
      pr24_q <= pr2_q;
    end
    if (adv[4]) begin
      last5_q <= e4_q.last;
      pb_q    <= 40'(m_q) * 40'(e4_q.g);
      pa5_q   <= pa4_q;
      pr25_q  <= pr24_q;
    end
    if (adv[5]) begin
      res_q <= res_d;
    end
  end

  assign out_data_o = res_q;

  a_p16_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> (p16_q >= 0) && (p16_q <= 16'sd16384))
    else $error("s*(1-s) out of range");

endmodule
`default_nettype wire

// File: rtl/gated_activation_unit.sv
`default_nettype none
// Channel   Dir  Handshake      Payload
// in_i      in   valid/ready    x_value, gate_value, upstream_grad, last_in
// out_o     out  valid/ready    primary_out, secondary_out, saturated, last_out
// cfg       in   cfg_we_i       cfg_idx_i, cfg_data_i (write only)
//
// One request enters per clock unless the full pipeline stalls at the output;
// the polynomial, sigmoid and gradient pipelines hold thirteen register stages.
// Reset clears the stage valid bits and sets both registers to zero.
// A stage holds its request while the stage after it is full and stalled, so
// bubbles close up and input is taken while a result waits at the output.
module gated_activation_unit (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  gau_pkg::cfg_idx_t                cfg_idx_i,
  input  wire [gau_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  gau_in_if.sink                           in_i,
  gau_out_if.source                        out_o
);
  import gau_pkg::*;

  // Configuration registers; the user must write them only while the pipeline is empty, the block does not enforce it.
  act_kind_e kind_q;
  logic      bwd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= ACT_SWIGLU;
      bwd_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ACT_KIND: kind_q <= act_kind_e'(cfg_data_i[1:0]);
        CFG_BACKWARD: bwd_q  <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  elem_t  in_elem;
  front_t front_data;
  sig_t   sig_data;
  res_t   res_data;
  logic   front_valid, front_ready;
  logic   sig_valid, sig_ready;

  assign in_elem.x    = in_i.x_value;
  assign in_elem.g    = in_i.gate_value;
  assign in_elem.go   = in_i.upstream_grad;
  assign in_elem.last = in_i.last_in;

  // Polynomial front end: forms the sigmoid argument and the tanh slope term.
  gau_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .kind_i      (kind_q),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_data_i   (in_elem),
    .out_valid_o (front_valid),
    .out_ready_i (front_ready),
    .out_data_o  (front_data)
  );

  // Table lookup with linear interpolation.
  gau_sigmoid u_sigmoid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .in_data_i   (front_data),
    .out_valid_o (sig_valid),
    .out_ready_i (sig_ready),
    .out_data_o  (sig_data)
  );

  // Derivative, products and final rounding; its last stage is the output
  // register.
  gau_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .kind_i      (kind_q),
    .backward_i  (bwd_q),
    .in_valid_i  (sig_valid),
    .in_ready_o  (sig_ready),
    .in_data_i   (sig_data),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (res_data)
  );

  assign out_o.primary_out   = res_data.primary;
  assign out_o.secondary_out = res_data.secondary;
  assign out_o.saturated     = res_data.saturated;
  assign out_o.last_out      = res_data.last;

endmodule
`default_nettype wire

// File: tb/gated_activation_unit_test.sv
`timescale 1ns / 100ps
`default_nettype none
module gated_activation_unit_test;
  import gau_pkg::*;

  // Sigmoid samples in Q16, rebuilt here from the defining integer recipe.
  longint sig_tab [TABLE_ENTRIES];

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  cfg_idx_t          cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  gau_in_if  req_ch ();
  gau_out_if res_ch ();

  gated_activation_unit dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (req_ch),
    .out_o     (res_ch)
  );

  // Mirror of the two configuration registers, updated from the write port.
  act_kind_e mirror_kind;
  bit        mirror_backward;

  res_t      expected_results [$];
  int        mismatches;
  int        stall_cycles;
  bit        idle_enable;   // random gaps on both sides
  bit        hold_request;  // asks the receiver for one long hold-off
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 20;   // comfortably above the 13-stage pipeline
  localparam int WATCHDOG_LIMIT = 5000;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Arithmetic of the predictor.
  // ---------------------------------------------------------------------------

  // Right shift with rounding to nearest, ties away from zero.
  function automatic longint round_shift(longint v, int n);
    longint half;
    if (n == 0) return v;
    half = longint'(1) <<< (n - 1);
    if (v >= 0) return (v + half) >>> n;
    return -((-v + half) >>> n);
  endfunction

  function automatic void fill_sigmoid_table();
    longint unsigned n, two_k, span, b, sum, term, e, den;
    n = TABLE_ENTRIES;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      two_k = 2 * k;
      span  = (two_k >= n) ? two_k - n : n - two_k;
      b     = ((span << 30) + n / 2) / n;
      sum   = 64'd1 << 30;
      term  = 64'd1 << 30;
      for (int i = 1; i <= 20; i++) begin
        term = ((term * b) >> 30) / i;
        sum += term;
      end
      e = (sum + 32) >> 6;
      for (int i = 0; i < 3; i++) e = (e * e + (64'd1 << 23)) >> 24;
      den = (64'd1 << 24) + e;
      if (two_k >= n) sig_tab[k] = longint'((64'd65536 * e + den / 2) / den);
      else sig_tab[k] = longint'(((64'd65536 << 24) + den / 2) / den);
    end
  endfunction

  // Table lookup with linear interpolation; argument and result in Q16.
  function automatic longint sigmoid_q16(longint z);
    longint zc, pos, idx, frac;
    zc   = (z < -524288) ? -524288 : ((z > 524288) ? 524288 : z);
    pos  = (zc + 524288) * TABLE_ENTRIES;
    idx  = pos >>> 20;
    frac = pos & 64'hFFFFF;
    if (idx >= TABLE_ENTRIES - 1) return sig_tab[TABLE_ENTRIES - 1];
    return sig_tab[idx] + round_shift((sig_tab[idx + 1] - sig_tab[idx]) * frac, 20);
  endfunction

  // Product rescaled by n bits, then clipped to the signed result range.
  function automatic longint scaled_product(longint a, longint b, int n, inout bit clip);
    longint unsigned ua, ub, r;
    bit neg;
    ua  = (a < 0) ? -a : a;
    ub  = (b < 0) ? -b : b;
    neg = (a < 0) != (b < 0);
    if (ua != 0 && ub > (64'd1 << 62) / ua) begin
      r = 64'd1 << 62;
    end else begin
      r = ua * ub;
      if (n > 0) r = (r + (64'd1 << (n - 1))) >> n;
    end
    if (r == 0) return 0;
    if (neg) begin
      if (r > 32768) begin
        clip = 1'b1;
        r = 32768;
      end
      return -longint'(r);
    end
    if (r > 32767) begin
      clip = 1'b1;
      r = 32767;
    end
    return longint'(r);
  endfunction

  // Expected result for one request under the mirrored configuration.
  function automatic res_t gated_result(logic signed [DATA_W-1:0] x_in,
                                        logic signed [DATA_W-1:0] g_in,
                                        logic signed [DATA_W-1:0] go_in,
                                        logic last);
    longint x, g, go, xc, xi, s, p16, act, deriv, r1, r2;
    longint x2, x3, inner, u, w, cx, t1;
    bit clip;
    res_t r;
    x = x_in;
    g = g_in;
    go = go_in;
    clip = 1'b0;
    r2 = 0;
    xc = (x < -32768) ? -32768 : ((x > 32768) ? 32768 : x);
    xi = xc * 16;
    case (mirror_kind)
      ACT_SWIGLU: begin
        s     = sigmoid_q16(xi);
        p16   = round_shift(s * (65536 - s), 16);
        deriv = s + round_shift(xi * p16, 16);
        act   = round_shift(x * s, 16);
      end
      ACT_GEGLU: begin
        x2    = round_shift(xi * xi, 16);
        x3    = round_shift(x2 * xi, 16);
        inner = xi + round_shift(longint'(750193) * x3, 24);
        u     = round_shift(longint'(13386282) * inner, 24);
        w     = 65536 + round_shift(longint'(3 * 750193) * x2, 24);
        cx    = round_shift(longint'(13386282) * xi, 24);
        t1    = round_shift(cx * w, 16);
        s     = sigmoid_q16(2 * u);
        p16   = round_shift(s * (65536 - s), 16);
        deriv = s + round_shift(2 * t1 * p16, 16);
        act   = round_shift(x * s, 16);
      end
      ACT_REGLU: begin
        act   = (x > 0) ? x : 0;
        deriv = (x > 0) ? 65536 : 0;
      end
      default: begin
        act   = x;
        deriv = 65536;
      end
    endcase
    if (mirror_backward) begin
      r1 = scaled_product(round_shift(go * deriv, 16), g, FRAC_BITS, clip);
      r2 = scaled_product(go, act, FRAC_BITS, clip);
    end else begin
      r1 = scaled_product(act, g, FRAC_BITS, clip);
    end
    r.primary   = r1[DATA_W-1:0];
    r.secondary = r2[DATA_W-1:0];
    r.saturated = clip;
    r.last      = last;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: every accepted request gets a prediction, every accepted result is
  // compared with the oldest prediction still waiting.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_ACT_KIND) mirror_kind = act_kind_e'(cfg_data_i[1:0]);
        else mirror_backward = cfg_data_i[0];
      end
      if (req_ch.valid && req_ch.ready)
        expected_results.push_back(gated_result(req_ch.x_value, req_ch.gate_value,
                                                req_ch.upstream_grad, req_ch.last_in));
      if (res_ch.valid && res_ch.ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: primary %0d secondary %0d sat %0b last %0b",
                     res_ch.primary_out, res_ch.secondary_out, res_ch.saturated,
                     res_ch.last_out);
        end else begin
          want = expected_results.pop_front();
          if (res_ch.primary_out !== want.primary || res_ch.secondary_out !== want.secondary
              || res_ch.saturated !== want.saturated || res_ch.last_out !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: expected primary %0d secondary %0d sat %0b last %0b,",
                        " got %0d %0d %0b %0b"}, want.primary, want.secondary,
                       want.saturated, want.last, res_ch.primary_out, res_ch.secondary_out,
                       res_ch.saturated, res_ch.last_out);
          end
        end
      end
    end
  end

  // Watchdog: too many cycles in a row with neither side moving a request.
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", expected_results.size());
        $display("gated_activation_unit_test: FAIL");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request so that
  // the pipeline fills and pushes back on the sender.
  initial begin
    res_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request = 1'b0;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12) - 1) @(posedge clk_i);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side.
  // ---------------------------------------------------------------------------

  // Offers one request and returns at the edge at which it is accepted. Valid
  // is left high so that back-to-back requests need no second assignment.
  task automatic send_element(logic [DATA_W-1:0] x, logic [DATA_W-1:0] g,
                              logic [DATA_W-1:0] go, logic last);
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    req_ch.valid         <= 1'b1;
    req_ch.x_value       <= x;
    req_ch.gate_value    <= g;
    req_ch.upstream_grad <= go;
    req_ch.last_in       <= last;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
  endtask

  // Drops valid and waits until every result is back and the pipeline is empty.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(act_kind_e kind, logic [CFG_DATA_W-1:0] backward);
    wait_drained();
    write_register(CFG_ACT_KIND, kind);
    write_register(CFG_BACKWARD, backward);
  endtask

  // Full-range operands half of the time, and otherwise small ones that keep the
  // products clear of saturation and exercise the curved part of the table.
  function automatic logic [DATA_W-1:0] random_operand();
    case ($urandom_range(0, 3))
      0: return DATA_W'($urandom_range(0, 16383) - 8192);
      1: return DATA_W'($urandom_range(0, 2047) - 1024);
      default: return DATA_W'($urandom);
    endcase
  endfunction

  task automatic send_random(int count);
    for (int i = 0; i < count; i++)
      send_element(random_operand(), random_operand(), random_operand(),
                   $urandom_range(0, 7) == 0);
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Operand extremes under every mode and both passes: positive and negative
  // full scale (x at the ends of the table span, products that clip) and zero.
  task automatic test_directed_extremes();
    for (int k = 0; k < 4; k++) begin
      for (int b = 0; b < 2; b++) begin
        configure(act_kind_e'(k), CFG_DATA_W'(b));
        send_element(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
        send_element(16'h8000, 16'h8000, 16'h8000, 1'b1);
        send_element(16'h0000, 16'h0001, 16'hFFFF, 1'b0);
      end
    end
  endtask

  // Every mode and pass with random operands and random gaps on both sides.
  // The backward register is also written with its unused upper bit set.
  task automatic test_random_modes();
    for (int k = 3; k >= 0; k--) begin
      configure(act_kind_e'(k), 2'b00);
      send_random(80);
      configure(act_kind_e'(k), (k == 0) ? 2'b11 : 2'b01);
      send_random(80);
    end
  endtask

  // The receiver holds off for a long stretch while requests keep coming, so
  // the pipeline fills and input stalls; afterwards the sender waits for the
  // pipeline to empty before carrying on.
  task automatic test_back_pressure();
    configure(ACT_GEGLU, 2'b01);
    hold_request = 1'b1;
    send_random(50);
    wait_drained();
    send_random(30);
  endtask

  // Closing stretch with no gaps on either side: full throughput.
  task automatic test_full_rate();
    configure(ACT_SWIGLU, 2'b00);
    idle_enable = 1'b0;
    send_random(60);
    configure(ACT_GEGLU, 2'b00);
    send_random(40);
  endtask

  initial begin
    fill_sigmoid_table();
    mirror_kind     = ACT_SWIGLU;
    mirror_backward = 1'b0;
    mismatches      = 0;
    stall_cycles    = 0;
    idle_enable     = 1'b1;
    hold_request    = 1'b0;
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_idx_i            <= CFG_ACT_KIND;
    cfg_data_i           <= '0;
    req_ch.valid         <= 1'b0;
    req_ch.x_value       <= '0;
    req_ch.gate_value    <= '0;
    req_ch.upstream_grad <= '0;
    req_ch.last_in       <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A few requests straight after reset check the reset configuration.
    send_random(4);
    test_directed_extremes();
    test_random_modes();
    test_back_pressure();
    test_full_rate();
    wait_drained();

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("gated_activation_unit_test: PASS");
    end else begin
      $display("gated_activation_unit_test: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: gated_activation_unit.f
rtl/gau_pkg.sv
rtl/gau_in_if.sv
rtl/gau_out_if.sv
rtl/gau_front.sv
rtl/gau_sigmoid.sv
rtl/gau_back.sv
rtl/gated_activation_unit.sv
tb/gated_activation_unit_test.sv
